>>> rtl/region_checked_register_map_assert.svh
// ----------------------------------------------------------------------------
// region checked register map assertion macros
// shorthand for clocked checks, all reset-qualified on the synchronous reset
// ----------------------------------------------------------------------------
`ifndef REGION_CHECKED_REGISTER_MAP_ASSERT_SVH
`define REGION_CHECKED_REGISTER_MAP_ASSERT_SVH

// condition that must hold at every clock edge outside reset
`define RCRM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle that forces another in the following cycle
`define RCRM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/rcrm_pkg.sv
// ----------------------------------------------------------------------------
// rcrm_pkg
// shared types, codes and region bounds of the region checked register map
// ----------------------------------------------------------------------------
package rcrm_pkg;

  // map geometry
  localparam int MAP_BYTES = 256;
  localparam int MAX_BURST = 64;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int CNT_W     = $clog2(MAX_BURST + 1);

  // writable spans: key plus define region, and the motor/system command regions
  localparam int WR_LO_LAST  = 15;
  localparam int DEF_FIRST   = 1;
  localparam int WR_HI_FIRST = 128;
  localparam int WR_HI_LAST  = 192;

  // register reset values
  localparam logic [7:0] UNLOCK_KEY_RST = 8'd165;
  localparam logic [7:0] VEL_FIRST_RST  = 8'd128;
  localparam logic [7:0] VEL_LAST_RST   = 8'd143;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_LEN = 2'd1,
    STAT_ACC = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_UNLOCK_KEY = 2'd0,
    CFG_VEL_FIRST  = 2'd1,
    CFG_VEL_LAST   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } rd_state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  start_addr;
    logic [7:0]  burst_len;
    logic        lock_flag;
    logic [31:0] now_tick;
    logic [7:0]  wdata;
  } rcrm_in_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  rdata;
    logic        is_last;
    logic [31:0] last_cmd_tick;
  } rcrm_out_t;

  // checker verdicts for one burst
  typedef struct packed {
    status_e rd_status;
    status_e wr_status;
    logic    overlap;
  } rcrm_chk_t;

  // store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } rcrm_wr_t;

endpackage

>>> rtl/region_checked_register_map.sv
// ----------------------------------------------------------------------------
// region_checked_register_map
// 256-byte register map with region checked burst reads and writes
// ----------------------------------------------------------------------------
// Write bursts arrive one word per beat and a beat is taken every cycle that
// busy is low; only the last beat of a burst returns a word, carrying the
// verdict fixed on the first beat. A good read of n bytes holds busy while the
// store is read through its single read port, one word per cycle, and until
// the last registered read word is returned; a refused read or a zero length
// write answers with one word on the cycle after it is taken. Results cannot
// be held off by the receiver.
// The store reads as all zero straight out of reset, with no clearing pass.
// Configuration is taken at any cycle (cfg_ready is tied high).
// ----------------------------------------------------------------------------
`include "region_checked_register_map_assert.svh"

module region_checked_register_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rcrm_pkg::rcrm_in_t  request,
  output logic                result_valid,
  output rcrm_pkg::rcrm_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import rcrm_pkg::*;

  // configuration
  logic [7:0] unlock_key;
  logic [7:0] vel_first;
  logic [7:0] vel_last;

  // write burst state
  logic              write_active;
  logic [ADDR_W-1:0] write_pointer;
  logic [7:0]        write_remaining;
  status_e           write_verdict;
  logic [31:0]       cmd_tick;

  // read sequencer
  rd_state_e         state;
  rd_state_e         state_next;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_issue;
  logic              rd_vld;
  logic              rd_last;

  // immediate result word
  logic    res_vld;
  status_e res_status;

  logic        accept;
  logic        acc_read;
  logic        acc_write;
  logic        good_read;
  logic        first_beat;
  rcrm_chk_t   chk;
  rcrm_wr_t    wr;
  logic [7:0]  byte0;
  logic [7:0]  mem_data;
  status_e     beat_verdict;
  logic [7:0]  beat_remaining;
  logic [7:0]  rem_after;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign acc_read  = accept && (request.opcode == OP_READ);
  assign acc_write = accept && (request.opcode == OP_WRITE);
  assign good_read = acc_read && (chk.rd_status == STAT_OK);
  assign first_beat = !write_active;

  rcrm_check u_check (
    .req        (request),
    .byte0      (byte0),
    .unlock_key (unlock_key),
    .vel_first  (vel_first),
    .vel_last   (vel_last),
    .chk        (chk)
  );

  rcrm_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (mem_data),
    .byte0   (byte0)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_key <= UNLOCK_KEY_RST;
      vel_first  <= VEL_FIRST_RST;
      vel_last   <= VEL_LAST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_UNLOCK_KEY: unlock_key <= cfg_data;
        CFG_VEL_FIRST:  vel_first  <= cfg_data;
        CFG_VEL_LAST:   vel_last   <= cfg_data;
        default: ;
      endcase
    end
  end

  // verdict, pointer and count of this beat
  always_comb begin
    if (first_beat) begin
      beat_verdict   = chk.wr_status;
      beat_remaining = request.burst_len;
      wr.addr        = request.start_addr;
    end else begin
      beat_verdict   = write_verdict;
      beat_remaining = write_remaining;
      wr.addr        = write_pointer;
    end
    rem_after = beat_remaining - 8'd1;
    wr.data   = request.wdata;
    wr.en     = acc_write && (beat_verdict == STAT_OK)
             && !(first_beat && (request.burst_len == 8'd0));
  end

  // write burst tracking and tick capture
  always_ff @(posedge clk) begin
    if (rst) begin
      write_active    <= 1'b0;
      write_pointer   <= '0;
      write_remaining <= 8'd0;
      write_verdict   <= STAT_OK;
      cmd_tick        <= 32'd0;
    end else if (acc_write && !(first_beat && (request.burst_len == 8'd0))) begin
      if (first_beat && (chk.wr_status == STAT_OK) && chk.overlap) begin
        cmd_tick <= request.now_tick;
      end
      write_active    <= (rem_after != 8'd0);
      write_pointer   <= wr.addr + ADDR_W'(1);
      write_remaining <= rem_after;
      write_verdict   <= beat_verdict;
    end
  end

  // single result words: refused reads, zero length writes, last write beats
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld    <= 1'b0;
      res_status <= STAT_OK;
    end else begin
      res_vld <= 1'b0;
      if (acc_read && (chk.rd_status != STAT_OK)) begin
        res_vld    <= 1'b1;
        res_status <= chk.rd_status;
      end else if (acc_write && first_beat && (request.burst_len == 8'd0)) begin
        res_vld    <= 1'b1;
        res_status <= STAT_LEN;
      end else if (acc_write && (rem_after == 8'd0)) begin
        res_vld    <= 1'b1;
        res_status <= beat_verdict;
      end
    end
  end

  // read sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (good_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read sequencer outputs
  always_comb begin
    rd_issue = (state == ST_READ);
    busy     = (state == ST_READ) || rd_vld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
      rd_addr <= '0;
      rd_cnt  <= '0;
    end else begin
      state   <= state_next;
      rd_vld  <= rd_issue;
      rd_last <= rd_issue && (rd_cnt == CNT_W'(1));
      if (acc_read) begin
        rd_addr <= request.start_addr;
        rd_cnt  <= request.burst_len[CNT_W-1:0];
      end else if (rd_issue) begin
        rd_addr <= rd_addr + ADDR_W'(1);
        rd_cnt  <= rd_cnt - CNT_W'(1);
      end
    end
  end

  // result word
  always_comb begin
    result_valid         = rd_vld || res_vld;
    result.last_cmd_tick = cmd_tick;
    if (rd_vld) begin
      result.status  = STAT_OK;
      result.rdata   = mem_data;
      result.is_last = rd_last;
    end else begin
      result.status  = res_status;
      result.rdata   = 8'd0;
      result.is_last = 1'b1;
    end
  end

  // checks
  `RCRM_ASSERT_ALWAYS(a_no_word_clash, !(rd_vld && res_vld), "read and single word clash")
  `RCRM_ASSERT_NEXT(a_read_starts, good_read, state == ST_READ, "good read not streamed")
  `RCRM_ASSERT_NEXT(a_stream_ends, rd_vld && rd_last, !rd_vld, "read stream overran")
  `RCRM_ASSERT_ALWAYS(a_burst_count, !write_active || (write_remaining != 8'd0), "burst count")

endmodule

>>> rtl/rcrm_check.sv
// ----------------------------------------------------------------------------
// rcrm_check
// length, region permission, unlock and command window checks of one burst
// ----------------------------------------------------------------------------
module rcrm_check (
  input  rcrm_pkg::rcrm_in_t  req,
  input  logic [7:0]          byte0,
  input  logic [7:0]          unlock_key,
  input  logic [7:0]          vel_first,
  input  logic [7:0]          vel_last,
  output rcrm_pkg::rcrm_chk_t chk
);
  import rcrm_pkg::*;

  logic [ADDR_W:0] span_end_x;
  logic [ADDR_W:0] last_addr;
  logic            len_bad;
  logic            in_lo;
  logic            in_hi;
  logic            locked_def;
  logic            perm_bad;
  logic            overlap;

  // burst end, one past and inclusive
  assign span_end_x = {1'b0, req.start_addr} + {1'b0, req.burst_len};
  assign last_addr  = span_end_x - (ADDR_W+1)'(1);

  // zero, over limit or past the end of the map
  assign len_bad = (req.burst_len == 8'd0)
                || ({1'b0, req.burst_len} > 9'(MAX_BURST))
                || (span_end_x > (ADDR_W+1)'(MAP_BYTES));

  // writable spans are contiguous, so the whole burst must sit inside one
  assign in_lo = last_addr <= (ADDR_W+1)'(WR_LO_LAST);
  assign in_hi = ({1'b0, req.start_addr} >= (ADDR_W+1)'(WR_HI_FIRST))
              && (last_addr <= (ADDR_W+1)'(WR_HI_LAST));

  // define region touched while byte 0 does not hold the key
  assign locked_def = in_lo && (last_addr >= (ADDR_W+1)'(DEF_FIRST))
                   && (byte0 != unlock_key);
  assign perm_bad   = !(in_lo || in_hi) || locked_def;

  // window overlap, taken as is for an inverted window
  assign overlap = (req.start_addr <= vel_last) && (last_addr >= {1'b0, vel_first});

  always_comb begin
    chk.overlap   = overlap;
    // every byte of the map is readable
    chk.rd_status = len_bad ? STAT_LEN : STAT_OK;
    if (len_bad) begin
      chk.wr_status = STAT_LEN;
    end else if (perm_bad || (overlap && req.lock_flag)) begin
      chk.wr_status = STAT_ACC;
    end else begin
      chk.wr_status = STAT_OK;
    end
  end

endmodule

>>> rtl/rcrm_store.sv
// ----------------------------------------------------------------------------
// rcrm_store
// byte store with one write and one registered read port, cleared by reset
// ----------------------------------------------------------------------------
module rcrm_store (
  input  logic                          clk,
  input  logic                          rst,
  input  rcrm_pkg::rcrm_wr_t            wr,
  input  logic                          rd_en,
  input  logic [rcrm_pkg::ADDR_W-1:0]   rd_addr,
  output logic [7:0]                    rd_data,
  output logic [7:0]                    byte0
);
  import rcrm_pkg::*;

  logic [7:0]           mem [MAP_BYTES];
  logic [MAP_BYTES-1:0] vld;
  logic [7:0]           rd_q;
  logic                 rd_hit;

  // memory array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // written marks, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_q : 8'd0;

  // copy of byte 0 for the unlock check
  always_ff @(posedge clk) begin
    if (rst) begin
      byte0 <= 8'd0;
    end else if (wr.en && (wr.addr == '0)) begin
      byte0 <= wr.data;
    end
  end

endmodule
